[src/fdv_pkg.sv]
// Shared types and constants for the filtered distinct value unit.
package fdv_pkg;

	localparam int VALUE_W    = 64;
	localparam int TAG_W      = 8;
	localparam int POS_W      = 10;
	localparam int CNT_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Largest values that the position and count fields can show.
	localparam int POS_MAX = 1023;
	localparam int CNT_MAX = 2047;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_ENABLE = 2'd0,
		REG_MATCH_KEY     = 2'd1
	} cfg_reg_t;

	// Controller states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_UPDATE = 3'b100
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the accepted item and restart the scan
		logic scan;    // walk the stored cells
		logic update;  // commit the table change and load the result register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;  // the scan found the value or ran past the stored cells
		logic out_free;   // the result register can take a new result
	} dp_sts_t;

endpackage

[src/fdv_in_if.sv]
// Input item channel: valid, ready and the item fields.
interface fdv_in_if;
	import fdv_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  value;
	logic signed [TAG_W-1:0]    tag;
	logic                       last;

	modport source (output valid, output value, output tag, output last, input ready);
	modport sink (input valid, input value, input tag, input last, output ready);
endinterface

[src/fdv_out_if.sv]
// Result channel: valid, ready and the result fields.
interface fdv_out_if;
	import fdv_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       is_new;
	logic signed [VALUE_W-1:0]  out_value;
	logic [POS_W-1:0]           position;
	logic [CNT_W-1:0]           distinct_count;
	logic                       overflow;
	logic                       end_of_run;

	modport source (
		output valid, output is_new, output out_value, output position,
		output distinct_count, output overflow, output end_of_run, input ready
	);
	modport sink (
		input valid, input is_new, input out_value, input position,
		input distinct_count, input overflow, input end_of_run, output ready
	);
endinterface

[src/fdv_cfg_if.sv]
// Configuration write channel: valid, ready, register index and data.
interface fdv_cfg_if;
	import fdv_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[src/fdv_ctrl.sv]
// Controller state machine that sequences capture, table scan and commit.
module fdv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output fdv_pkg::dp_cmd_t cmd,
	input  fdv_pkg::dp_sts_t sts
);
	import fdv_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_next;

	always_comb begin
		state_next = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_next = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (sts.out_free) begin
					cmd.update = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end
endmodule

[src/fdv_dpath.sv]
// Datapath: value table memory, scan counter, column state and result register.
module fdv_dpath #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [fdv_pkg::VALUE_W-1:0] in_value,
	input  logic signed [fdv_pkg::TAG_W-1:0]   in_tag,
	input  logic                               in_last,
	fdv_out_if.source                          out_ch,
	fdv_cfg_if.sink                            cfg,
	input  fdv_pkg::dp_cmd_t                   cmd,
	output fdv_pkg::dp_sts_t                   sts
);
	import fdv_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SW = (CW > CNT_W) ? CW : CNT_W;

	// Configuration registers.
	logic                    filter_enable_q;
	logic signed [TAG_W-1:0] match_key_q;

	// Current item.
	logic signed [VALUE_W-1:0] value_q;
	logic                      last_q;
	logic                      admit_q;

	// Column state.
	logic [CW-1:0] count_q;
	logic          ovf_q;

	// Scan machinery.
	logic [VALUE_W-1:0] mem [TABLE_DEPTH];
	logic [CW-1:0]      scan_idx_q;
	logic               rd_pend_q;
	logic               hit_q;
	logic [VALUE_W-1:0] rdata_q;
	logic               issue;
	logic               hit_now;

	// Result register.
	logic                      out_valid_q;
	logic                      is_new_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [POS_W-1:0]          position_q;
	logic [CNT_W-1:0]          count_out_q;
	logic                      ovf_out_q;
	logic                      eor_q;

	// Commit logic.
	logic          is_new;
	logic          has_room;
	logic [CW-1:0] pos_full;
	logic [CW-1:0] count_next;
	logic          ovf_next;
	logic [SW-1:0] pos_wide;
	logic [SW-1:0] cnt_wide;
	logic [POS_W-1:0] pos_sat;
	logic [CNT_W-1:0] cnt_sat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= 1'b0;
			match_key_q     <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FILTER_ENABLE: filter_enable_q <= cfg.data[0];
				REG_MATCH_KEY:     match_key_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	// A read is issued for each stored cell until the value is found.
	assign issue   = cmd.scan && admit_q && !hit_q && (scan_idx_q < count_q);
	assign hit_now = rd_pend_q && (rdata_q == value_q);

	assign sts.scan_done = hit_q || (!issue && !rd_pend_q);
	assign sts.out_free  = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk) begin
		rdata_q <= mem[scan_idx_q[AW-1:0]];
		if (cmd.update && is_new && has_room) begin
			mem[count_q[AW-1:0]] <= value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= in_value;
			last_q  <= in_last;
			admit_q <= !filter_enable_q || (in_tag == match_key_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_pend_q  <= 1'b0;
			hit_q      <= 1'b0;
		end else if (cmd.load) begin
			scan_idx_q <= '0;
			rd_pend_q  <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			rd_pend_q <= issue;
			if (issue) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
			if (hit_now) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_comb begin
		is_new     = admit_q && !hit_q;
		has_room   = count_q < CW'(TABLE_DEPTH);
		pos_full   = has_room ? count_q : CW'(TABLE_DEPTH - 1);
		count_next = count_q;
		ovf_next   = ovf_q;
		if (is_new) begin
			if (has_room) begin
				count_next = count_q + CW'(1);
			end else begin
				ovf_next = 1'b1;
			end
		end
		pos_wide = SW'(pos_full);
		cnt_wide = SW'(count_next);
		pos_sat  = (pos_wide > SW'(POS_MAX)) ? POS_W'(POS_MAX) : pos_wide[POS_W-1:0];
		cnt_sat  = (cnt_wide > SW'(CNT_MAX)) ? CNT_W'(CNT_MAX) : cnt_wide[CNT_W-1:0];
		if (!is_new) begin
			pos_sat = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.update) begin
			if (last_q) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_next;
				ovf_q   <= ovf_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			is_new_q    <= is_new;
			out_value_q <= value_q;
			position_q  <= pos_sat;
			count_out_q <= cnt_sat;
			ovf_out_q   <= ovf_next;
			eor_q       <= last_q;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.is_new         = is_new_q;
	assign out_ch.out_value      = out_value_q;
	assign out_ch.position       = position_q;
	assign out_ch.distinct_count = count_out_q;
	assign out_ch.overflow       = ovf_out_q;
	assign out_ch.end_of_run     = eor_q;
endmodule

[src/filtered_distinct_values_unit.sv]
// An empty table, a filtered-out item or an early match ends the scan sooner.
// One item at a time; the next is taken once the previous result is registered.
// The scan reads one stored cell per cycle from the table memory, which sets the rate.
// Reset (arst_n low) clears the column count, overflow flag, configuration and handshakes.
// The value table itself is not cleared; only cells below the count are ever compared.
module filtered_distinct_values_unit #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	fdv_in_if.sink     in_ch,
	fdv_out_if.source  out_ch,
	fdv_cfg_if.sink    cfg
);
	import fdv_pkg::*;

	// Command and status between the controller and the datapath.
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    ctl_in_ready;

	// The controller only takes an input transaction while idle. It then steps
	// through the scan of the stored values and commits the result once the
	// result register is free, so a waiting result delays the commit and the next capture.
	fdv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (ctl_in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	assign in_ch.ready = ctl_in_ready;

	// The datapath holds the table memory, the column count and overflow flag,
	// the configuration registers and the result register that drives the
	// output transaction.
	fdv_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_value (in_ch.value),
		.in_tag   (in_ch.tag),
		.in_last  (in_ch.last),
		.out_ch   (out_ch),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts)
	);
endmodule
